FILE: rtl/bq_pkg.sv
// shared types, constants and control program for the multichannel biquad
`default_nettype none
package bq_pkg;

	localparam int COEF_W    = 24;
	localparam int COEF_FRAC = 22;
	localparam int NUM_COEFS = 5;
	localparam int CHAN_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int STEP_W    = 3;

	localparam logic [COEF_W-1:0] B0_RESET = 24'd4194304;
	localparam logic [COEF_W-1:0] COEF_ZERO = 24'd0;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} cfg_reg_t;

	typedef logic [STEP_W-1:0] step_t;

	// sequencing of one step
	typedef enum logic [1:0] {
		SEQ_NEXT,
		SEQ_WAIT_IN,
		SEQ_END
	} seq_op_t;

	typedef enum logic [2:0] {
		COEF_B0,
		COEF_B1,
		COEF_B2,
		COEF_A1,
		COEF_A2
	} coef_sel_t;

	typedef enum logic {
		SRC_X,
		SRC_Y
	} mul_src_t;

	// main accumulator operations
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_PROD_S1,
		ACC_PROD_S2,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		seq_op_t   seq;
		coef_sel_t coef;
		mul_src_t  src;
		acc_op_t   acc;
		logic      b_load;
		logic      y_load;
		logic      fin;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
	} cond_t;

	typedef logic [COEF_W-1:0] coef_t;
	typedef coef_t [NUM_COEFS-1:0] coef_bank_t;

	localparam step_t LAST_STEP = 3'd6;

	// control program, one word per step
	function automatic ctrl_t prog_rom(input step_t step);
		ctrl_t w;
		w = '{seq: SEQ_NEXT, coef: COEF_B0, src: SRC_X, acc: ACC_HOLD,
			b_load: 1'b0, y_load: 1'b0, fin: 1'b0};
		case (step)
			3'd0: w.seq = SEQ_WAIT_IN;
			3'd1: begin
				w.coef = COEF_B0;
			end
			3'd2: begin
				w.acc  = ACC_PROD_S1;
				w.coef = COEF_B1;
			end
			3'd3: begin
				w.y_load = 1'b1;
				w.acc    = ACC_PROD_S2;
				w.coef   = COEF_B2;
			end
			3'd4: begin
				w.b_load = 1'b1;
				w.coef   = COEF_A1;
				w.src    = SRC_Y;
			end
			3'd5: begin
				w.acc  = ACC_SUB;
				w.coef = COEF_A2;
				w.src  = SRC_Y;
			end
			// keep the a2*y product steady while the result waits
			3'd6: begin
				w.seq  = SEQ_END;
				w.fin  = 1'b1;
				w.coef = COEF_A2;
				w.src  = SRC_Y;
			end
			default: w.seq = SEQ_END;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bq_seq.sv
// step counter and control store of the biquad microprogram
`default_nettype none
module bq_seq (
	input  wire           clk,
	input  wire           arst_n,
	input  bq_pkg::cond_t cond,
	output bq_pkg::ctrl_t ctrl,
	output logic          go
);
	import bq_pkg::*;

	step_t step_q;

	// current control word
	assign ctrl = prog_rom(step_q);

	// step completion condition
	always_comb begin
		case (ctrl.seq)
			SEQ_NEXT:    go = 1'b1;
			SEQ_WAIT_IN: go = cond.in_valid;
			SEQ_END:     go = cond.out_free;
			default:     go = 1'b1;
		endcase
	end

	// step counter with jump back to start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (go) begin
			if (ctrl.seq == SEQ_END) begin
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= LAST_STEP) else $error("step counter beyond program");
`endif

endmodule
`default_nettype wire

FILE: rtl/bq_dp.sv
// multiply-accumulate datapath with per-channel state memories
`default_nettype none
module bq_dp #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  bq_pkg::ctrl_t                ctrl,
	input  wire                          go,
	input  wire                          accept,
	input  wire signed [SAMPLE_BITS-1:0] sample_in,
	input  wire [bq_pkg::CHAN_W-1:0]     channel_in,
	input  bq_pkg::coef_bank_t           coefs,
	output logic [SAMPLE_BITS-1:0]       y_out,
	output logic [bq_pkg::CHAN_W-1:0]    ch_out
);
	import bq_pkg::*;

	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STATE_W = SAMPLE_BITS + 32;
	localparam int PROD_W  = SAMPLE_BITS + COEF_W;
	localparam int SH_W    = STATE_W - COEF_FRAC;
	localparam logic signed [STATE_W-1:0] HALF = STATE_W'(2 ** (COEF_FRAC - 1));
	localparam logic signed [SH_W-1:0] MAXV = SH_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [SH_W-1:0] MINV = -MAXV - SH_W'(1);

	logic signed [STATE_W-1:0] d1_mem [CHANNELS];
	logic signed [STATE_W-1:0] d2_mem [CHANNELS];
	logic [CHANNELS-1:0]       valid_q;

	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic [CHAN_W-1:0]             ch_q;
	logic [IDX_W-1:0]              idx_q;
	logic                          have_q;
	logic                          vld_q;
	logic signed [STATE_W-1:0]     rd1_q;
	logic signed [STATE_W-1:0]     rd2_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [STATE_W-1:0]     acc_q;
	logic signed [STATE_W-1:0]     b_q;

	logic [IDX_W-1:0]              idx;
	logic                          have;
	logic signed [STATE_W-1:0]     s1;
	logic signed [STATE_W-1:0]     s2;
	logic signed [STATE_W-1:0]     prod_ext;
	logic signed [STATE_W-1:0]     d2_next;
	logic signed [COEF_W-1:0]      coef_op;
	logic signed [SAMPLE_BITS-1:0] mul_op;
	logic signed [STATE_W-1:0]     rnd;
	logic signed [SH_W-1:0]        shifted;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic                          wr;

	// channel decode
	assign have = 32'(channel_in) < CHANNELS;
	assign idx  = IDX_W'(channel_in);

	// capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_in;
			ch_q   <= channel_in;
			idx_q  <= idx;
			have_q <= have;
			vld_q  <= valid_q[idx];
			rd1_q  <= d1_mem[idx];
			rd2_q  <= d2_mem[idx];
		end
	end

	// unwritten or missing channels read as zero state
	assign s1 = (have_q && vld_q) ? rd1_q : '0;
	assign s2 = (have_q && vld_q) ? rd2_q : '0;

	// multiplier operand selection
	always_comb begin
		case (ctrl.coef)
			COEF_B0: coef_op = coefs[REG_B0];
			COEF_B1: coef_op = coefs[REG_B1];
			COEF_B2: coef_op = coefs[REG_B2];
			COEF_A1: coef_op = coefs[REG_A1];
			COEF_A2: coef_op = coefs[REG_A2];
			default: coef_op = '0;
		endcase
	end
	assign mul_op = (ctrl.src == SRC_Y) ? y_q : x_q;

	always_ff @(posedge clk) begin
		prod_q <= coef_op * mul_op;
	end

	assign prod_ext = STATE_W'(prod_q);
	assign d2_next  = b_q - prod_ext;

	// accumulators
	always_ff @(posedge clk) begin
		case (ctrl.acc)
			ACC_PROD_S1: acc_q <= prod_ext + s1;
			ACC_PROD_S2: acc_q <= prod_ext + s2;
			ACC_SUB:     acc_q <= acc_q - prod_ext;
			default:     acc_q <= acc_q;
		endcase
		if (ctrl.b_load) begin
			b_q <= prod_ext;
		end
	end

	// round half up and saturate
	assign rnd     = acc_q + HALF;
	assign shifted = SH_W'(rnd >>> COEF_FRAC);
	always_comb begin
		if (shifted > MAXV) begin
			y_sat = SAMPLE_BITS'(MAXV);
		end else if (shifted < MINV) begin
			y_sat = SAMPLE_BITS'(MINV);
		end else begin
			y_sat = shifted[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.y_load) begin
			y_q <= y_sat;
		end
	end

	// state write back
	assign wr = go && ctrl.fin && have_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			d1_mem[idx_q] <= acc_q;
			d2_mem[idx_q] <= d2_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	assign y_out  = y_q;
	assign ch_out = ch_q;

endmodule
`default_nettype wire

FILE: rtl/biquad_tdf2_multichannel.sv
// top level of the multichannel transposed direct form II biquad
// a request is taken only in the first step of the seven-step microprogram, so a new
// sample waits until the last one is written back; the microprogram shares one multiplier
// across the five products, and its final step stalls until the output register is free
// reset: coefficients take their reset values, all channel state reads as zero
// through per-channel valid flags; no clearing pass
`default_nettype none
module biquad_tdf2_multichannel #(
	parameter int CHANNELS    = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// sample_in, channel_in
	input  wire [((SAMPLE_BITS+3+7)/8)*8-1:0]    s_tdata,
	input  wire                                  s_tvalid,
	output logic                                 s_tready,
	// sample_out, channel_out
	output logic [((SAMPLE_BITS+3+7)/8)*8-1:0]   m_tdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	input  wire                                  cfg_we,
	input  wire [bq_pkg::CFG_IDX_W-1:0]          cfg_addr,
	input  wire [bq_pkg::COEF_W-1:0]             cfg_data
);
	import bq_pkg::*;

	localparam int DATA_W = ((SAMPLE_BITS + CHAN_W + 7) / 8) * 8;

	coef_bank_t coef_q;
	ctrl_t      ctrl;
	cond_t      cond;
	logic       go;
	logic       accept;
	logic       m_tvalid_q;
	logic [SAMPLE_BITS-1:0] y_out;
	logic [CHAN_W-1:0]      ch_out;
	logic [SAMPLE_BITS-1:0] y_q;
	logic [CHAN_W-1:0]      ch_q;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_B0] <= B0_RESET;
			coef_q[REG_B1] <= COEF_ZERO;
			coef_q[REG_B2] <= COEF_ZERO;
			coef_q[REG_A1] <= COEF_ZERO;
			coef_q[REG_A2] <= COEF_ZERO;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_B0:  coef_q[REG_B0] <= cfg_data;
				REG_B1:  coef_q[REG_B1] <= cfg_data;
				REG_B2:  coef_q[REG_B2] <= cfg_data;
				REG_A1:  coef_q[REG_A1] <= cfg_data;
				REG_A2:  coef_q[REG_A2] <= cfg_data;
				default: coef_q <= coef_q;
			endcase
		end
	end

	// handshake and sequencer conditions
	assign s_tready      = (ctrl.seq == SEQ_WAIT_IN);
	assign accept        = s_tvalid && s_tready;
	assign cond.in_valid = s_tvalid;
	assign cond.out_free = !m_tvalid_q || m_tready;

	bq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl),
		.go     (go)
	);

	bq_dp #(
		.CHANNELS    (CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.go         (go),
		.accept     (accept),
		.sample_in  (s_tdata[SAMPLE_BITS-1:0]),
		.channel_in (s_tdata[SAMPLE_BITS+CHAN_W-1 -: CHAN_W]),
		.coefs      (coef_q),
		.y_out      (y_out),
		.ch_out     (ch_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (go && ctrl.fin) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && ctrl.fin) begin
			y_q  <= y_out;
			ch_q <= ch_out;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_W'({ch_q, y_q});

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("request taken while program runs");
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctrl.fin) |=> m_tvalid) else $error("finished result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(go && ctrl.fin) |-> (!m_tvalid_q || m_tready))
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

FILE: tb/biquad_tdf2_multichannel_tb.sv
// self-checking testbench for the multichannel biquad: random streams checked against a predictor
module biquad_tdf2_multichannel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bq_pkg::*;

	localparam int CHANNELS          = 8;
	localparam int SAMPLE_BITS       = 16;
	localparam int DATA_W            = ((SAMPLE_BITS + CHAN_W + 7) / 8) * 8;
	localparam int CLK_PERIOD        = 10;
	localparam int RESET_CYCLES      = 11;
	localparam int NUM_BANKS         = 12;
	localparam int SAMPLES_PER_BANK  = 108;
	localparam int HOLD_CYCLES       = 300;
	// extra settling wait after the queues drain
	localparam int SETTLE_CYCLES     = 12;
	localparam longint SAMPLE_MAX    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN    = -SAMPLE_MAX - 1;
	localparam coef_t COEF_MAX       = coef_t'((1 << (COEF_W - 1)) - 1);
	localparam coef_t COEF_MIN       = coef_t'(1 << (COEF_W - 1));
	localparam coef_t COEF_HALF      = coef_t'(1 << (COEF_FRAC - 1));

	// one stream word, laid out as on tdata
	typedef struct packed {
		logic [CHAN_W-1:0]      channel;
		logic [SAMPLE_BITS-1:0] sample;
	} audio_word_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic [DATA_W-1:0]    s_tdata  = '0;
	logic                 s_tvalid = 1'b0;
	wire                  s_tready;
	wire  [DATA_W-1:0]    m_tdata;
	wire                  m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	coef_t                cfg_data = '0;

	// predictor copy of coefficients and per-channel state
	logic signed [COEF_W-1:0] coef_bank [NUM_COEFS];
	longint                   tap1_state [CHANNELS];
	longint                   tap2_state [CHANNELS];

	audio_word_t pending_samples[$];
	audio_word_t expected_samples[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit in_taken      = 1'b0;
	bit hold_req      = 1'b0;
	int hold_left     = 0;
	int errors        = 0;
	int accepted      = 0;
	int checked       = 0;
	int saturated     = 0;
	int coef_writes   = 0;

	biquad_tdf2_multichannel #(
		.CHANNELS(CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one filter step: output from current state, then state update with clipped y
	function automatic audio_word_t filter_sample(input audio_word_t req);
		longint x, acc, y, s1, s2;
		longint b0, b1, b2, a1, a2;
		bit has_state;
		audio_word_t res;
		x  = longint'($signed(req.sample));
		b0 = coef_bank[REG_B0];
		b1 = coef_bank[REG_B1];
		b2 = coef_bank[REG_B2];
		a1 = coef_bank[REG_A1];
		a2 = coef_bank[REG_A2];
		has_state = req.channel < CHANNELS;
		s1 = has_state ? tap1_state[req.channel] : 64'sd0;
		s2 = has_state ? tap2_state[req.channel] : 64'sd0;
		acc = b0 * x + s1;
		// halves round up, then clip to the sample range
		y = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
		if (y > SAMPLE_MAX) begin
			y = SAMPLE_MAX;
			saturated++;
		end else if (y < SAMPLE_MIN) begin
			y = SAMPLE_MIN;
			saturated++;
		end
		if (has_state) begin
			tap1_state[req.channel] = b1 * x - a1 * y + s2;
			tap2_state[req.channel] = b2 * x - a2 * y;
		end
		res.sample  = y[SAMPLE_BITS-1:0];
		res.channel = req.channel;
		return res;
	endfunction

	// result check and prediction of accepted requests
	always @(posedge clk) begin : check_results
		audio_word_t want, got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[SAMPLE_BITS+CHAN_W-1:0];
			if (expected_samples.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual sample %0d channel %0d",
					$time, $signed(got.sample), got.channel);
			end else begin
				want = expected_samples.pop_front();
				checked++;
				if (got.sample !== want.sample) begin
					errors++;
					$display("%0t: sample mismatch, expected %0d actual %0d (channel %0d)",
						$time, $signed(want.sample), $signed(got.sample), want.channel);
				end
				if (got.channel !== want.channel) begin
					errors++;
					$display("%0t: channel mismatch, expected %0d actual %0d",
						$time, want.channel, got.channel);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			expected_samples.push_back(filter_sample(s_tdata[SAMPLE_BITS+CHAN_W-1:0]));
			accepted++;
			in_taken = 1'b1;
		end
	end

	// request driver with random gaps
	always @(negedge clk) begin : drive_samples
		logic next_valid;
		audio_word_t req;
		next_valid = s_tvalid && !in_taken;
		in_taken = 1'b0;
		if (!next_valid && pending_samples.size() != 0 &&
				$urandom_range(99) >= send_idle_pct) begin
			req = pending_samples.pop_front();
			s_tdata <= DATA_W'(req);
			next_valid = 1'b1;
		end
		s_tvalid <= next_valid;
	end

	// result side ready, with random stalls and one long hold-off
	always @(negedge clk) begin : drive_ready
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_COEFS)
			coef_bank[idx] = value;
		coef_writes++;
	endtask

	task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
			input coef_t a1, input coef_t a2);
		write_coef(REG_B0, b0);
		write_coef(REG_B1, b1);
		write_coef(REG_B2, b2);
		write_coef(REG_A1, a1);
		write_coef(REG_A2, a2);
	endtask

	task automatic queue_sample(input longint x, input int ch);
		audio_word_t req;
		req.sample  = x[SAMPLE_BITS-1:0];
		req.channel = ch[CHAN_W-1:0];
		pending_samples.push_back(req);
	endtask

	// block until every request is in and every result is out
	task automatic wait_idle();
		while (pending_samples.size() != 0 || s_tvalid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly full-range samples, some extremes and some small values
	function automatic longint pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 70)
			return longint'($urandom);
		if (roll < 85) begin
			case ($urandom_range(4))
				0: return SAMPLE_MAX;
				1: return SAMPLE_MIN;
				2: return 64'sd0;
				3: return -64'sd1;
				default: return 64'sd1;
			endcase
		end
		return longint'($urandom_range(512)) - 256;
	endfunction

	// coefficient styles: full range, small, extremes or zero only, or a mix
	function automatic coef_t pick_coef(input int kind);
		int v;
		case (kind)
			0: return coef_t'($urandom);
			1: begin
				v = int'($urandom_range(1 << 21)) - (1 << 20);
				return coef_t'(v);
			end
			2: begin
				case ($urandom_range(2))
					0: return COEF_MAX;
					1: return COEF_MIN;
					default: return COEF_ZERO;
				endcase
			end
			default: begin
				v = int'($urandom_range(1 << 21)) - (1 << 20);
				return $urandom_range(1) ? coef_t'($urandom) : coef_t'(v);
			end
		endcase
	endfunction

	initial begin : run_regression
		int kind;
		coef_bank[REG_B0] = B0_RESET;
		coef_bank[REG_B1] = COEF_ZERO;
		coef_bank[REG_B2] = COEF_ZERO;
		coef_bank[REG_A1] = COEF_ZERO;
		coef_bank[REG_A2] = COEF_ZERO;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			tap1_state[ch] = 64'sd0;
			tap2_state[ch] = 64'sd0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 31;
		recv_idle_pct = 78;

		// reset coefficients pass the sample straight through
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MIN, 1);
		queue_sample(0, 2);
		queue_sample(-1, 3);
		queue_sample(1, 7);
		wait_idle();

		// gain of one half: exact halves round toward plus infinity
		write_coef(REG_B0, COEF_HALF);
		queue_sample(1, 4);
		queue_sample(-1, 5);
		queue_sample(3, 6);
		queue_sample(-3, 6);
		wait_idle();

		// extreme coefficients clip in both directions; out-of-range indexes are ignored
		load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
		for (int k = NUM_COEFS; k < (1 << CFG_IDX_W); k++)
			write_coef(CFG_IDX_W'(k), COEF_ZERO);
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MAX, 0);
		queue_sample(SAMPLE_MIN, 0);
		queue_sample(SAMPLE_MIN, 0);
		wait_idle();

		load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
		queue_sample(SAMPLE_MIN, 1);
		queue_sample(SAMPLE_MAX, 1);
		queue_sample(0, 1);
		queue_sample(0, 1);
		wait_idle();

		// random banks of coefficients, each with a random sample stream
		for (int bank_idx = 0; bank_idx < NUM_BANKS; bank_idx++) begin
			if (bank_idx == NUM_BANKS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 31;
			end else if (bank_idx == 2 * NUM_BANKS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			kind = bank_idx % 4;
			load_coefs(pick_coef(kind), pick_coef(kind), pick_coef(kind),
				pick_coef(kind), pick_coef(kind));
			if ($urandom_range(1))
				write_coef(CFG_IDX_W'(NUM_COEFS + $urandom_range(2)), coef_t'($urandom));
			for (int n = 0; n < SAMPLES_PER_BANK; n++)
				queue_sample(pick_sample(), $urandom_range(CHANNELS - 1));
			// long result-side stall while requests keep coming
			if (bank_idx == 2 * NUM_BANKS / 3) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			wait_idle();
		end

		$display("covered %0d samples on %0d channels over %0d coefficient sets, %0d results checked",
			accepted, CHANNELS, NUM_BANKS + 4, checked);
		$display("%0d outputs clipped, %0d register writes including unused indexes",
			saturated, coef_writes);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: biquad_tdf2_multichannel.f
rtl/bq_pkg.sv
rtl/bq_seq.sv
rtl/bq_dp.sv
rtl/biquad_tdf2_multichannel.sv
tb/biquad_tdf2_multichannel_tb.sv
